// ===== sv/tccnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccnt_pkg
// Shared op codes, field widths and fixed constants of the completion
// counter table.
// ----------------------------------------------------------------------------
package tccnt_pkg;

    localparam int OP_W       = 3;
    localparam int TAG_IN_W   = 16;
    localparam int RANK_IN_W  = 6;
    localparam int TOKEN_IN_W = 16;
    localparam int BASE_W     = 25;
    localparam int ECOUNT_W   = 24;
    localparam int FRESH_W    = 17;
    localparam int TOTAL_W    = 30;
    localparam int RANKS_W    = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_RECORD    = 3'd0;
    localparam op_t OP_QUERY     = 3'd1;
    localparam op_t OP_TOTAL     = 3'd2;
    localparam op_t OP_CLEAR_TAG = 3'd3;
    localparam op_t OP_CLEAR_ALL = 3'd4;

    localparam logic CFG_RANKS_IN_USE = 1'b0;

    localparam logic [RANKS_W-1:0] RANKS_RESET = 7'd64;
    localparam logic [FRESH_W-1:0] FRESH_NONE  = 17'h1FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 30'h3FFFFFFF;

endpackage

// ===== sv/tccnt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccnt_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tccnt_ram #(
    parameter int WIDTH  = 25,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tccnt_tag_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccnt_tag_mod
// Two-stage tag reduction modulo MAX_TAGS: reciprocal multiply for the
// quotient estimate, then back-multiply, subtract and one correction.
// ----------------------------------------------------------------------------
module tccnt_tag_mod #(
    parameter int MAX_TAGS = 1024,
    parameter int TAG_W    = $clog2(MAX_TAGS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tccnt_pkg::TAG_IN_W-1:0] tag,
    output logic                          done,
    output logic [TAG_W-1:0]              row
);

    localparam logic [63:0] RECIP_L = (64'd1 << 32) / MAX_TAGS;
    localparam logic [31:0] RECIP   = RECIP_L[31:0];

    logic                           v1_reg;
    logic [15:0]                    q1_reg;
    logic [tccnt_pkg::TAG_IN_W-1:0] tag1_reg;
    logic                           done_reg;
    logic [TAG_W-1:0]               row_reg;

    logic [47:0] prod;
    logic [32:0] qm;
    logic [32:0] diff;
    logic [16:0] rem;
    logic [16:0] rem_fix;

    assign prod    = 48'(tag) * 48'(RECIP);
    assign qm      = 33'(q1_reg) * 33'(MAX_TAGS);
    assign diff    = 33'(tag1_reg) - qm;
    assign rem     = diff[16:0];
    assign rem_fix = (rem >= 17'(MAX_TAGS)) ? (rem - 17'(MAX_TAGS)) : rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        q1_reg   <= prod[47:32];
        tag1_reg <= tag;
        row_reg  <= rem_fix[TAG_W-1:0];
    end

    assign done = done_reg;
    assign row  = row_reg;

endmodule

// ===== sv/tagged_completion_counter_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_completion_counter_table
// Completion counters addressed by (tag mod MAX_TAGS, rank), held in a count
// memory and a token memory, with record, query, tag total and clear ops.
// One word is taken at a time. After acceptance the tag passes through the
// modulo unit; a record then does one read and one write-back on the count
// memory, and an entry query reads the count and token memories. A tag total
// walks the count memory one rank per cycle. A tag clear writes MAX_RANKS
// entries, one per cycle; a full clear writes every entry. After reset a
// clearing pass over all MAX_TAGS * 2^ceil(log2 MAX_RANKS) entries runs on
// the count memory before the first word is taken; configuration writes are
// taken throughout.
// ----------------------------------------------------------------------------
module tagged_completion_counter_table #(
    parameter int MAX_TAGS   = 1024,
    parameter int MAX_RANKS  = 64,
    parameter int COUNT_BITS = 24,
    parameter int TOKEN_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tccnt_pkg::PADDR_W-1:0]     paddr,
    input  logic [tccnt_pkg::PDATA_W-1:0]     pwdata,
    output logic [tccnt_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tccnt_pkg::OP_W-1:0]        s_op,
    input  logic [tccnt_pkg::TAG_IN_W-1:0]    s_tag,
    input  logic [tccnt_pkg::RANK_IN_W-1:0]   s_rank,
    input  logic                              s_has_token,
    input  logic [tccnt_pkg::TOKEN_IN_W-1:0]  s_token_value,
    input  logic signed [tccnt_pkg::BASE_W-1:0] s_baseline,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tccnt_pkg::ECOUNT_W-1:0]    m_entry_count,
    output logic signed [tccnt_pkg::FRESH_W-1:0] m_fresh_token,
    output logic [tccnt_pkg::TOTAL_W-1:0]     m_tag_total
);

    localparam int TAG_W  = $clog2(MAX_TAGS);
    localparam int RANK_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
    localparam int NR_W   = $clog2(MAX_RANKS + 1);
    localparam int ADDR_W = TAG_W + RANK_W;
    localparam int DEPTH  = MAX_TAGS * (1 << RANK_W);
    localparam int A_W    = COUNT_BITS + 1;
    localparam int B_W    = TOKEN_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [tccnt_pkg::RANKS_W-1:0] ranks_reg;

    tccnt_pkg::op_t                     op_reg, op_next;
    logic [tccnt_pkg::RANK_IN_W-1:0]    rank_reg, rank_next;
    logic                               has_tok_reg, has_tok_next;
    logic [TOKEN_BITS-1:0]              tok_reg, tok_next;
    logic signed [tccnt_pkg::BASE_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0]                  addr_reg, addr_next;
    logic [TAG_W-1:0]                   row_reg, row_next;

    logic [NR_W-1:0]                    wk_idx_reg, wk_idx_next;
    logic                               rd_pend_reg, rd_pend_next;
    logic [tccnt_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic [ADDR_W-1:0]                  clr_reg, clr_next;
    logic [ADDR_W-1:0]                  clr_last_reg, clr_last_next;

    logic                               m_valid_reg, m_valid_next;
    logic [tccnt_pkg::ECOUNT_W-1:0]     m_entry_count_reg, m_entry_count_next;
    logic [tccnt_pkg::FRESH_W-1:0]      m_fresh_token_reg, m_fresh_token_next;
    logic [tccnt_pkg::TOTAL_W-1:0]      m_tag_total_reg, m_tag_total_next;

    logic              a_we, a_re, b_we, b_re;
    logic [ADDR_W-1:0] a_waddr, a_raddr;
    logic [A_W-1:0]    a_wdata, a_rdata;
    logic [B_W-1:0]    b_wdata, b_rdata;

    logic              tm_start, tm_done;
    logic [TAG_W-1:0]  tm_row;
    logic [ADDR_W-1:0] tm_addr;

    logic [RANK_W+tccnt_pkg::RANK_IN_W-1:0] rank_wide;
    logic [RANK_W-1:0]      rank_idx;
    logic [8:0]             ranks_9;
    logic [NR_W-1:0]        nr;
    logic                   rank_ok;
    logic                   out_free;
    logic                   cfg_wr;

    logic [COUNT_BITS-1:0]  a_cnt, cnt_new;
    logic                   a_vld;
    logic [TOKEN_BITS-1:0]  b_tok;
    logic [COUNT_BITS-1:0]  b_arr;
    logic signed [32:0]     arr_s, base_s;
    logic                   fresh_hit;
    logic [31:0]            cnt32;
    logic [31:0]            sum32;
    logic [tccnt_pkg::TOTAL_W-1:0] total_sat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == tccnt_pkg::CFG_RANKS_IN_USE) ?
                    tccnt_pkg::PDATA_W'(ranks_reg) : '0;

    // derived values
    assign ranks_9   = {2'b00, ranks_reg};
    assign nr        = (ranks_9 < 9'(MAX_RANKS)) ? NR_W'(ranks_9) : NR_W'(MAX_RANKS);
    assign rank_ok   = (rank_reg < nr);
    assign rank_wide = {{RANK_W{1'b0}}, rank_reg};
    assign rank_idx  = rank_wide[RANK_W-1:0];
    assign tm_addr   = {tm_row, rank_idx};
    assign out_free  = !m_valid_reg || m_ready;

    assign a_cnt   = a_rdata[A_W-1:1];
    assign a_vld   = a_rdata[0];
    assign b_tok   = b_rdata[B_W-1:COUNT_BITS];
    assign b_arr   = b_rdata[COUNT_BITS-1:0];
    assign cnt_new = (a_cnt == COUNT_MAX) ? a_cnt : (a_cnt + 1'b1);
    assign arr_s   = $signed({{(33-COUNT_BITS){1'b0}}, b_arr});
    assign base_s  = $signed({{(33-tccnt_pkg::BASE_W){base_reg[tccnt_pkg::BASE_W-1]}},
                              base_reg});
    assign fresh_hit = a_vld && (arr_s > base_s);
    assign cnt32     = {{(32-COUNT_BITS){1'b0}}, a_cnt};
    assign sum32     = {2'b00, total_reg} + cnt32;
    assign total_sat = (sum32 > 32'(tccnt_pkg::TOTAL_MAX)) ? tccnt_pkg::TOTAL_MAX :
                       sum32[tccnt_pkg::TOTAL_W-1:0];

    assign s_ready  = (state_reg == S_IDLE);
    assign tm_start = s_valid && s_ready;

    tccnt_tag_mod #(
        .MAX_TAGS (MAX_TAGS),
        .TAG_W    (TAG_W)
    ) u_tag_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tm_start),
        .tag     (s_tag),
        .done    (tm_done),
        .row     (tm_row)
    );

    tccnt_ram #(
        .WIDTH  (A_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    tccnt_ram #(
        .WIDTH  (B_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_token_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (addr_reg),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (tm_addr),
        .rdata (b_rdata)
    );

    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        rank_next          = rank_reg;
        has_tok_next       = has_tok_reg;
        tok_next           = tok_reg;
        base_next          = base_reg;
        addr_next          = addr_reg;
        row_next           = row_reg;
        wk_idx_next        = wk_idx_reg;
        rd_pend_next       = rd_pend_reg;
        total_next         = total_reg;
        clr_next           = clr_reg;
        clr_last_next      = clr_last_reg;
        m_valid_next       = m_valid_reg;
        m_entry_count_next = m_entry_count_reg;
        m_fresh_token_next = m_fresh_token_reg;
        m_tag_total_next   = m_tag_total_reg;
        a_we    = 1'b0;
        a_waddr = clr_reg;
        a_wdata = '0;
        a_re    = 1'b0;
        a_raddr = tm_addr;
        b_we    = 1'b0;
        b_wdata = {tok_reg, cnt_new};
        b_re    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next      = s_op;
                    rank_next    = s_rank;
                    has_tok_next = s_has_token;
                    tok_next     = s_token_value[TOKEN_BITS-1:0];
                    base_next    = s_baseline;
                    state_next   = S_MOD;
                end
            end
            S_MOD: begin
                if (tm_done) begin
                    row_next  = tm_row;
                    addr_next = tm_addr;
                    case (op_reg)
                        tccnt_pkg::OP_RECORD: begin
                            if (rank_ok) begin
                                a_re       = 1'b1;
                                state_next = S_EXEC;
                            end else begin
                                state_next = S_IDLE;
                            end
                        end
                        tccnt_pkg::OP_QUERY: begin
                            a_re       = 1'b1;
                            b_re       = 1'b1;
                            state_next = S_EXEC;
                        end
                        tccnt_pkg::OP_TOTAL: begin
                            wk_idx_next  = '0;
                            rd_pend_next = 1'b0;
                            total_next   = '0;
                            state_next   = S_WALK;
                        end
                        tccnt_pkg::OP_CLEAR_TAG: begin
                            clr_next      = {tm_row, {RANK_W{1'b0}}};
                            clr_last_next = {tm_row, RANK_W'(MAX_RANKS - 1)};
                            state_next    = S_CLEAR;
                        end
                        tccnt_pkg::OP_CLEAR_ALL: begin
                            clr_next      = '0;
                            clr_last_next = ADDR_W'(DEPTH - 1);
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (op_reg == tccnt_pkg::OP_RECORD) begin
                    a_we       = 1'b1;
                    a_waddr    = addr_reg;
                    a_wdata    = {cnt_new, a_vld | has_tok_reg};
                    b_we       = has_tok_reg;
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_entry_count_next = rank_ok ? cnt32[tccnt_pkg::ECOUNT_W-1:0] : '0;
                    m_fresh_token_next = (rank_ok && fresh_hit) ?
                        {{(tccnt_pkg::FRESH_W-TOKEN_BITS){1'b0}}, b_tok} :
                        tccnt_pkg::FRESH_NONE;
                    m_tag_total_next   = '0;
                    state_next         = S_IDLE;
                end
            end
            S_WALK: begin
                if (rd_pend_reg) begin
                    total_next = total_sat;
                end
                if (wk_idx_reg < nr) begin
                    a_re         = 1'b1;
                    a_raddr      = {row_reg, wk_idx_reg[RANK_W-1:0]};
                    wk_idx_next  = NR_W'(wk_idx_reg + 1'b1);
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg && out_free) begin
                        m_valid_next       = 1'b1;
                        m_entry_count_next = '0;
                        m_fresh_token_next = tccnt_pkg::FRESH_NONE;
                        m_tag_total_next   = total_reg;
                        wk_idx_next        = '0;
                        total_next         = '0;
                        state_next         = S_IDLE;
                    end
                end
            end
            S_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = '0;
                if (clr_reg == clr_last_reg) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            ranks_reg    <= tccnt_pkg::RANKS_RESET;
            wk_idx_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            total_reg    <= '0;
            clr_reg      <= '0;
            clr_last_reg <= ADDR_W'(DEPTH - 1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wk_idx_reg   <= wk_idx_next;
            rd_pend_reg  <= rd_pend_next;
            total_reg    <= total_next;
            clr_reg      <= clr_next;
            clr_last_reg <= clr_last_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr && (paddr[2] == tccnt_pkg::CFG_RANKS_IN_USE)) begin
                ranks_reg <= pwdata[tccnt_pkg::RANKS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg            <= op_next;
        rank_reg          <= rank_next;
        has_tok_reg       <= has_tok_next;
        tok_reg           <= tok_next;
        base_reg          <= base_next;
        addr_reg          <= addr_next;
        row_reg           <= row_next;
        m_entry_count_reg <= m_entry_count_next;
        m_fresh_token_reg <= m_fresh_token_next;
        m_tag_total_reg   <= m_tag_total_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_fresh_token = $signed(m_fresh_token_reg);
    assign m_tag_total   = m_tag_total_reg;

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_WALK))
        else $error("result word raised outside query or walk");

    a_walk_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> !a_we)
        else $error("count memory written during tag walk");

    a_walk_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(a_re))
        else $error("walk accumulates without a preceding read");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tm_done |-> (tm_row < MAX_TAGS))
        else $error("reduced tag out of range");

    a_clear_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (clr_reg <= clr_last_reg))
        else $error("clearing pass ran past its last entry");

endmodule
